// ===== hw/rtl/button_click_hold_detector_unit_assert.svh =====
// Assertion macros for the button click and hold detector.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef BUTTON_CLICK_HOLD_DETECTOR_UNIT_ASSERT_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BCHD_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");
`define BCHD_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");
`else
`define BCHD_ASSERT_SAME(label, pre, post)
`define BCHD_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== hw/rtl/bchd_pkg.sv =====
`timescale 1ns / 1ps

package bchd_pkg;

	localparam int BUTTONS_DEF = 5;
	localparam int FIELD_W = 5;
	localparam int TIME_W = 32;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd3;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd40;
	localparam logic [CFG_W-1:0] HOLD_RST = 16'd500;
	localparam logic [CFG_W-1:0] DOUBLE_RST = 16'd250;
	localparam logic [CFG_W-1:0] REPEAT_RST = 16'd100;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_DEB_PRESS,
		PH_PRESSED,
		PH_DEB_RELEASE,
		PH_WAIT_DOUBLE
	} phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] hold_time;
		logic [CFG_W-1:0] double_click_window;
		logic [CFG_W-1:0] repeat_period;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]  now_ms;
		logic [FIELD_W-1:0] pressed;
		logic [FIELD_W-1:0] hold;
		logic [FIELD_W-1:0] click;
		logic [FIELD_W-1:0] dbl;
	} item_t;

endpackage

// ===== hw/rtl/bchd_cell.sv =====
`timescale 1ns / 1ps

module bchd_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bchd_pkg::cfg_t  cfg,
	input  logic            up_valid,
	input  bchd_pkg::item_t up_item,
	output logic            up_ready,
	output logic            dn_valid,
	output bchd_pkg::item_t dn_item,
	input  logic            dn_ready
);

	bchd_pkg::phase_t phase_q, phase_d;
	logic [bchd_pkg::TIME_W-1:0] phase_start_q, phase_start_d;
	logic [bchd_pkg::TIME_W-1:0] repeat_start_q, repeat_start_d;
	logic hold_seen_q, hold_seen_d;
	logic valid_s1;
	bchd_pkg::item_t item_s1, item_d;
	logic take, pr;
	logic ev_hold, ev_click, ev_dbl;
	logic [bchd_pkg::TIME_W-1:0] el_phase, el_repeat;
	logic exp_deb, exp_hold, exp_win, exp_rep;
	logic [bchd_pkg::FIELD_W-1:0] sel;

	assign up_ready = !valid_s1 || dn_ready;
	assign take = up_valid && up_ready;
	assign dn_valid = valid_s1;
	assign dn_item = item_s1;

	assign sel = bchd_pkg::FIELD_W'(1) << IDX;
	assign pr = |(up_item.pressed & sel);

	assign el_phase = up_item.now_ms - phase_start_q;
	assign el_repeat = up_item.now_ms - repeat_start_q;
	assign exp_deb = el_phase >= {16'd0, cfg.debounce_time};
	assign exp_hold = el_phase >= {16'd0, cfg.hold_time};
	assign exp_win = el_phase >= {16'd0, cfg.double_click_window};
	assign exp_rep = el_repeat >= {16'd0, cfg.repeat_period};

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			bchd_pkg::PH_DEB_PRESS: begin
				if (!pr) begin
					phase_d = bchd_pkg::PH_IDLE;
				end else if (exp_deb) begin
					phase_d = bchd_pkg::PH_PRESSED;
				end
			end
			bchd_pkg::PH_PRESSED: begin
				if (!pr) begin
					phase_d = bchd_pkg::PH_DEB_RELEASE;
				end
			end
			bchd_pkg::PH_DEB_RELEASE: begin
				if (pr) begin
					phase_d = bchd_pkg::PH_PRESSED;
				end else if (exp_deb) begin
					phase_d = hold_seen_q ? bchd_pkg::PH_IDLE : bchd_pkg::PH_WAIT_DOUBLE;
				end
			end
			bchd_pkg::PH_WAIT_DOUBLE: begin
				if (pr || exp_win) begin
					phase_d = bchd_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = pr ? bchd_pkg::PH_DEB_PRESS : bchd_pkg::PH_IDLE;
			end
		endcase
	end

	always_comb begin
		phase_start_d = phase_start_q;
		repeat_start_d = repeat_start_q;
		hold_seen_d = hold_seen_q;
		ev_hold = 1'b0;
		ev_click = 1'b0;
		ev_dbl = 1'b0;
		unique case (phase_q)
			bchd_pkg::PH_DEB_PRESS: begin
				if (pr && exp_deb) begin
					phase_start_d = up_item.now_ms;
					hold_seen_d = 1'b0;
				end
			end
			bchd_pkg::PH_PRESSED: begin
				if (!pr) begin
					phase_start_d = up_item.now_ms;
				end else if (!hold_seen_q) begin
					if (exp_hold) begin
						hold_seen_d = 1'b1;
						repeat_start_d = up_item.now_ms;
						ev_hold = 1'b1;
					end
				end else if (exp_rep) begin
					repeat_start_d = up_item.now_ms;
					ev_hold = 1'b1;
				end
			end
			bchd_pkg::PH_DEB_RELEASE: begin
				if (!pr && exp_deb && !hold_seen_q) begin
					phase_start_d = up_item.now_ms;
				end
			end
			bchd_pkg::PH_WAIT_DOUBLE: begin
				if (pr) begin
					phase_start_d = up_item.now_ms;
					ev_dbl = 1'b1;
				end else if (exp_win) begin
					ev_click = 1'b1;
				end
			end
			default: begin
				if (pr) begin
					phase_start_d = up_item.now_ms;
				end
			end
		endcase
	end

	always_comb begin
		item_d = up_item;
		item_d.hold = up_item.hold | ({bchd_pkg::FIELD_W{ev_hold}} & sel);
		item_d.click = up_item.click | ({bchd_pkg::FIELD_W{ev_click}} & sel);
		item_d.dbl = up_item.dbl | ({bchd_pkg::FIELD_W{ev_dbl}} & sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bchd_pkg::PH_IDLE;
			hold_seen_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				hold_seen_q <= hold_seen_d;
			end
			if (up_ready) begin
				valid_s1 <= up_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			phase_start_q <= phase_start_d;
			repeat_start_q <= repeat_start_d;
			item_s1 <= item_d;
		end
	end

endmodule

// ===== hw/rtl/button_click_hold_detector_unit.sv =====
`timescale 1ns / 1ps
// Button click, double click and hold detector.
// Each poll item carries now_ms, a free-running millisecond count, and
// pressed_mask with one bit per button. A poll is taken at a clock edge with
// poll_valid high and poll_stall low. Every poll yields exactly one result
// item with hold_mask, click_mask and double_mask, taken at an edge with
// result_valid high and result_stall low.
// The poll walks a row of cells, one per button, and each cell updates its
// button's machine and sets that button's event bits as the item passes.
// The item passes each cell's stage register in turn. A new poll can be taken
// every cycle while poll_stall is low, and polls keep entering while a finished
// result waits; when the receiver stalls, the row fills up and poll_stall rises
// once the first cell's stage is held. Reset puts every button in idle, empties
// the row and loads the timing registers with 40, 500, 250 and 100 ms. Timing
// registers must be written through cfg_wen, cfg_index and cfg_data while no
// poll is in flight; the user must keep to this, as the block does no check.

module button_click_hold_detector_unit #(
	parameter int BUTTONS = bchd_pkg::BUTTONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           poll_valid,
	output logic                           poll_stall,
	input  logic [bchd_pkg::TIME_W-1:0]    now_ms,
	input  logic [bchd_pkg::FIELD_W-1:0]   pressed_mask,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [bchd_pkg::FIELD_W-1:0]   hold_mask,
	output logic [bchd_pkg::FIELD_W-1:0]   click_mask,
	output logic [bchd_pkg::FIELD_W-1:0]   double_mask,
	input  logic                           cfg_wen,
	input  logic [bchd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bchd_pkg::CFG_W-1:0]     cfg_data
);

	bchd_pkg::cfg_t cfg_q;
	logic link_valid [BUTTONS+1];
	logic link_ready [BUTTONS+1];
	bchd_pkg::item_t link_item [BUTTONS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time <= bchd_pkg::DEBOUNCE_RST;
			cfg_q.hold_time <= bchd_pkg::HOLD_RST;
			cfg_q.double_click_window <= bchd_pkg::DOUBLE_RST;
			cfg_q.repeat_period <= bchd_pkg::REPEAT_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				bchd_pkg::CFG_DEBOUNCE: cfg_q.debounce_time <= cfg_data;
				bchd_pkg::CFG_HOLD: cfg_q.hold_time <= cfg_data;
				bchd_pkg::CFG_DOUBLE: cfg_q.double_click_window <= cfg_data;
				bchd_pkg::CFG_REPEAT: cfg_q.repeat_period <= cfg_data;
			endcase
		end
	end

	assign link_valid[0] = poll_valid;
	assign link_item[0].now_ms = now_ms;
	assign link_item[0].pressed = pressed_mask;
	assign link_item[0].hold = '0;
	assign link_item[0].click = '0;
	assign link_item[0].dbl = '0;
	assign poll_stall = !link_ready[0];

	for (genvar k = 0; k < BUTTONS; k++) begin : g_cell
		bchd_cell #(
			.IDX(k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg_q),
			.up_valid (link_valid[k]),
			.up_item  (link_item[k]),
			.up_ready (link_ready[k]),
			.dn_valid (link_valid[k+1]),
			.dn_item  (link_item[k+1]),
			.dn_ready (link_ready[k+1])
		);
	end

	assign link_ready[BUTTONS] = !result_stall;
	assign result_valid = link_valid[BUTTONS];
	assign hold_mask = link_item[BUTTONS].hold;
	assign click_mask = link_item[BUTTONS].click;
	assign double_mask = link_item[BUTTONS].dbl;

`include "button_click_hold_detector_unit_assert.svh"

	`BCHD_ASSERT_SAME(a_one_event, result_valid, ((hold_mask & click_mask) | (hold_mask & double_mask) | (click_mask & double_mask)) == '0)
	`BCHD_ASSERT_SAME(a_stall_full, poll_stall, link_valid[1])
	`BCHD_ASSERT_NEXT(a_cfg_hold, cfg_wen && cfg_index == bchd_pkg::CFG_HOLD, cfg_q.hold_time == $past(cfg_data))

endmodule
